### design/ladrc_pkg.sv
// Package: payload types, register indexes and fixed-point constants for the LADRC core.
package ladrc_pkg;

	localparam int STATE_WIDTH = 48;
	localparam int FRAC_BITS   = 16;
	localparam int H_SHIFT     = 24;
	localparam int DRIVE_LIMIT_INT = 30000;
	localparam int ADDR_WIDTH  = 5;

	localparam logic [ADDR_WIDTH-3:0] REG_STEP_TIME    = 3'd0;
	localparam logic [ADDR_WIDTH-3:0] REG_TRACK_SPEED  = 3'd1;
	localparam logic [ADDR_WIDTH-3:0] REG_CONTROL_BW   = 3'd2;
	localparam logic [ADDR_WIDTH-3:0] REG_OBSERVER_BW  = 3'd3;
	localparam logic [ADDR_WIDTH-3:0] REG_PLANT_GAIN   = 3'd4;

	typedef struct packed {
		logic               action;
		logic signed [31:0] setpoint;
		logic signed [31:0] measurement;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               clamped;
	} out_word_t;

	// ALU operation codes for the shared unit
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2
	} alu_op_t;

endpackage

### design/ladrc_alu.sv
// Shared saturating add, subtract and rounding multiply unit with a registered result.
module ladrc_alu #(
	parameter int STATE_WIDTH = ladrc_pkg::STATE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  ladrc_pkg::alu_op_t            op,
	input  logic signed [STATE_WIDTH-1:0] a,
	input  logic signed [STATE_WIDTH-1:0] b,
	input  logic [4:0]                    sh,
	output logic                          done,
	output logic signed [STATE_WIDTH-1:0] y
);
	localparam int W = STATE_WIDTH;
	localparam int HW = (W + 1) / 2;
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0]   ma_q, mb_q;
	logic           neg_q;
	logic [2*W-1:0] acc_q;
	logic [4:0]     sh_q;
	logic [2:0]     phase_q;
	logic           busy_q;

	logic signed [W:0] sum;
	logic signed [W-1:0] addres;
	logic [W-1:0] ma, mb;
	logic [HW-1:0] pa, pb;
	logic [2*HW-1:0] pp;
	logic [2*W-1:0] ppx, rnd, shr;
	logic [W-1:0] mag;
	logic ovf;

	always_comb begin
		sum = (op == ladrc_pkg::OP_SUB) ? ({a[W-1], a} - {b[W-1], b})
			: ({a[W-1], a} + {b[W-1], b});
		if (sum[W] != sum[W-1])
			addres = sum[W] ? SMIN : SMAX;
		else
			addres = sum[W-1:0];
		ma = a[W-1] ? W'(-a) : W'(a);
		mb = b[W-1] ? W'(-b) : W'(b);
		pa = (phase_q[1]) ? HW'(ma_q >> HW) : ma_q[HW-1:0];
		pb = (phase_q[0]) ? HW'(mb_q >> HW) : mb_q[HW-1:0];
		pp = pa * pb;
		ppx = (2*W)'(pp) << ((phase_q[1] ? HW : 0) + (phase_q[0] ? HW : 0));
		rnd = (sh_q == 5'd0) ? acc_q : acc_q + ((2*W)'(1) << (sh_q - 5'd1));
		shr = rnd >> sh_q;
		ovf = (shr >> (W - 1)) != '0;
		mag = shr[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ma_q    <= '0;
			mb_q    <= '0;
			neg_q   <= 1'b0;
			sh_q    <= '0;
			acc_q   <= '0;
			phase_q <= '0;
			busy_q  <= 1'b0;
			done    <= 1'b0;
			y       <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				if (op == ladrc_pkg::OP_MUL) begin
					ma_q    <= ma;
					mb_q    <= mb;
					neg_q   <= a[W-1] != b[W-1];
					sh_q    <= sh;
					acc_q   <= '0;
					phase_q <= 3'd0;
					busy_q  <= 1'b1;
				end else begin
					y    <= addres;
					done <= 1'b1;
				end
			end else if (busy_q) begin
				if (phase_q == 3'd4) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					if (ovf)
						y <= neg_q ? SMIN : SMAX;
					else
						y <= neg_q ? W'(-mag) : W'(mag);
				end else begin
					acc_q   <= acc_q + ppx;
					phase_q <= phase_q + 3'd1;
				end
			end
		end
	end
endmodule

### design/ladrc_div.sv
// Restoring divider: clamp check and bit-serial quotient for the drive.
module ladrc_div #(
	parameter int STATE_WIDTH = ladrc_pkg::STATE_WIDTH,
	parameter int FRAC_BITS   = ladrc_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [STATE_WIDTH-1:0] num,
	input  logic [30:0]                   den,
	output logic                          done,
	output logic signed [31:0]            q,
	output logic                          clip
);
	localparam int W  = STATE_WIDTH;
	localparam int NW = W + FRAC_BITS;
	localparam logic [63:0] LIM_FULL = 64'(ladrc_pkg::DRIVE_LIMIT_INT) << FRAC_BITS;
	localparam logic [31:0] LIMIT = (LIM_FULL > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
		: LIM_FULL[31:0];
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [31:0]   rem_q;
	logic [30:0]   den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [W-1:0] mag;
	logic [NW-1:0] shifted;
	logic [30:0] den_eff;
	logic [63:0] lim_prod;
	logic big;
	logic [32:0] trial;

	always_comb begin
		mag = num[W-1] ? W'(-num) : W'(num);
		shifted = NW'(mag) << FRAC_BITS;
		den_eff = (den == '0) ? 31'd1 : den;
		lim_prod = (64'(LIMIT) + 64'd1) * 64'(den_eff);
		big = (NW > 64) ? ((NW'(shifted) >> 63) != '0 || 64'(shifted) >= lim_prod)
			: (65'(shifted) >= 65'(lim_prod));
		trial = {rem_q, dvd_q[NW-1]} - {2'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			den_q  <= 31'd1;
			dvd_q  <= '0;
			rem_q  <= '0;
			clip   <= 1'b0;
			q      <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				neg_q <= num[W-1];
				den_q <= den_eff;
				if (big) begin
					clip <= 1'b1;
					q    <= num[W-1] ? -LIMIT : LIMIT;
					done <= 1'b1;
				end else begin
					clip   <= 1'b0;
					dvd_q  <= shifted;
					rem_q  <= '0;
					cnt_q  <= CW'(NW);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					q      <= neg_q ? -dvd_q[31:0] : dvd_q[31:0];
				end else begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						dvd_q <= {dvd_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], dvd_q[NW-1]};
						dvd_q <= {dvd_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end
endmodule

### design/second_order_ladrc_controller_core.sv
// Top level: LADRC control step sequenced over a shared arithmetic unit.
//  channel | dir | handshake              | word
//  in      | in  | in_valid / in_stall    | ladrc_pkg::in_word_t
//  out     | out | out_valid / out_stall  | ladrc_pkg::out_word_t
//  cfg     | in  | APB psel/penable       | 32-bit registers at 4*i
// One control step: 40 operations on the shared unit, 17 multiplies and
// 23 adds or subtracts, then the divider, which skips its quotient loop on a clamp;
// the next word is taken only once the previous output word has been accepted.
// A clear word is taken without starting a step and gives no output word.
// Reset clears all states and registers to defaults. in_stall is high while a word is
// in work or an output word waits; out_valid holds until out_stall is low.
module second_order_ladrc_controller_core #(
	parameter int STATE_WIDTH = ladrc_pkg::STATE_WIDTH,
	parameter int FRAC_BITS   = ladrc_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ladrc_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ladrc_pkg::out_word_t out_word,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ladrc_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam int W = STATE_WIDTH;
	localparam logic [4:0] SF = 5'(FRAC_BITS);
	localparam logic [4:0] SH = 5'(ladrc_pkg::H_SHIFT);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	// register file of the sequencer
	typedef enum logic [4:0] {
		R_X, R_Y, R_R, R_WC, R_W0, R_H, R_B0, R_LD,
		R_V1, R_V2, R_Z1, R_Z2, R_Z3,
		R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_ZERO
	} reg_t;

	state_t state_q;
	logic [23:0] h_q, r_q, wc_q, w0_q;
	logic [30:0] b0_q;
	logic signed [W-1:0] rf_q [20];
	logic [5:0] pc_q;
	logic alu_start_q, div_start_q;
	logic alu_done, div_done;
	logic signed [W-1:0] alu_y;
	logic signed [31:0] div_q;
	logic div_clip;

	typedef struct packed {
		ladrc_pkg::alu_op_t op;
		reg_t a;
		reg_t b;
		reg_t d;
		logic [4:0] sh;
	} instr_t;

	instr_t ins;

	always_comb begin
		ins = '{ladrc_pkg::OP_ADD, R_ZERO, R_ZERO, R_T0, 5'd0};
		case (pc_q)
			6'd0:  ins = '{ladrc_pkg::OP_MUL, R_R, R_R, R_T0, SF};
			6'd1:  ins = '{ladrc_pkg::OP_SUB, R_V1, R_X, R_T1, 5'd0};
			6'd2:  ins = '{ladrc_pkg::OP_MUL, R_T0, R_T1, R_T0, SF};
			6'd3:  ins = '{ladrc_pkg::OP_SUB, R_ZERO, R_T0, R_T0, 5'd0};
			6'd4:  ins = '{ladrc_pkg::OP_ADD, R_R, R_R, R_T1, 5'd0};
			6'd5:  ins = '{ladrc_pkg::OP_MUL, R_T1, R_V2, R_T1, SF};
			6'd6:  ins = '{ladrc_pkg::OP_SUB, R_T0, R_T1, R_T0, 5'd0};
			6'd7:  ins = '{ladrc_pkg::OP_MUL, R_V2, R_H, R_T1, SH};
			6'd8:  ins = '{ladrc_pkg::OP_MUL, R_T0, R_H, R_T0, SH};
			6'd9:  ins = '{ladrc_pkg::OP_ADD, R_V1, R_T1, R_V1, 5'd0};
			6'd10: ins = '{ladrc_pkg::OP_ADD, R_V2, R_T0, R_V2, 5'd0};
			6'd11: ins = '{ladrc_pkg::OP_MUL, R_W0, R_W0, R_T2, SF};
			6'd12: ins = '{ladrc_pkg::OP_ADD, R_W0, R_W0, R_T3, 5'd0};
			6'd13: ins = '{ladrc_pkg::OP_ADD, R_T3, R_W0, R_T3, 5'd0};
			6'd14: ins = '{ladrc_pkg::OP_MUL, R_T2, R_W0, R_T4, SF};
			6'd15: ins = '{ladrc_pkg::OP_ADD, R_T2, R_T2, R_T5, 5'd0};
			6'd16: ins = '{ladrc_pkg::OP_ADD, R_T5, R_T2, R_T2, 5'd0};
			6'd17: ins = '{ladrc_pkg::OP_SUB, R_Z1, R_Y, R_T5, 5'd0};
			6'd18: ins = '{ladrc_pkg::OP_MUL, R_T3, R_T5, R_T0, SF};
			6'd19: ins = '{ladrc_pkg::OP_SUB, R_Z2, R_T0, R_T0, 5'd0};
			6'd20: ins = '{ladrc_pkg::OP_MUL, R_T0, R_H, R_T0, SH};
			6'd21: ins = '{ladrc_pkg::OP_ADD, R_Z1, R_T0, R_T3, 5'd0};
			6'd22: ins = '{ladrc_pkg::OP_MUL, R_T2, R_T5, R_T0, SF};
			6'd23: ins = '{ladrc_pkg::OP_SUB, R_Z3, R_T0, R_T0, 5'd0};
			6'd24: ins = '{ladrc_pkg::OP_MUL, R_B0, R_LD, R_T1, SF};
			6'd25: ins = '{ladrc_pkg::OP_ADD, R_T0, R_T1, R_T0, 5'd0};
			6'd26: ins = '{ladrc_pkg::OP_MUL, R_T0, R_H, R_T0, SH};
			6'd27: ins = '{ladrc_pkg::OP_ADD, R_Z2, R_T0, R_Z2, 5'd0};
			6'd28: ins = '{ladrc_pkg::OP_MUL, R_T4, R_T5, R_T0, SF};
			6'd29: ins = '{ladrc_pkg::OP_MUL, R_T0, R_H, R_T0, SH};
			6'd30: ins = '{ladrc_pkg::OP_SUB, R_Z3, R_T0, R_Z3, 5'd0};
			6'd31: ins = '{ladrc_pkg::OP_ADD, R_T3, R_ZERO, R_Z1, 5'd0};
			6'd32: ins = '{ladrc_pkg::OP_SUB, R_V1, R_Z1, R_T0, 5'd0};
			6'd33: ins = '{ladrc_pkg::OP_SUB, R_V2, R_Z2, R_T1, 5'd0};
			6'd34: ins = '{ladrc_pkg::OP_MUL, R_WC, R_WC, R_T2, SF};
			6'd35: ins = '{ladrc_pkg::OP_MUL, R_T2, R_T0, R_T2, SF};
			6'd36: ins = '{ladrc_pkg::OP_ADD, R_WC, R_WC, R_T3, 5'd0};
			6'd37: ins = '{ladrc_pkg::OP_MUL, R_T3, R_T1, R_T3, SF};
			6'd38: ins = '{ladrc_pkg::OP_ADD, R_T2, R_T3, R_T2, 5'd0};
			6'd39: ins = '{ladrc_pkg::OP_SUB, R_T2, R_Z3, R_T2, 5'd0};
			default: ins = '{ladrc_pkg::OP_ADD, R_ZERO, R_ZERO, R_T0, 5'd0};
		endcase
	end

	localparam logic [5:0] LAST_PC = 6'd39;

	ladrc_alu #(.STATE_WIDTH(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start_q),
		.op     (ins.op),
		.a      (rf_q[ins.a]),
		.b      (rf_q[ins.b]),
		.sh     (ins.sh),
		.done   (alu_done),
		.y      (alu_y)
	);

	ladrc_div #(.STATE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (rf_q[R_T2]),
		.den    (b0_q),
		.done   (div_done),
		.q      (div_q),
		.clip   (div_clip)
	);

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		unique case (paddr[ladrc_pkg::ADDR_WIDTH-1:2])
			ladrc_pkg::REG_STEP_TIME:   prdata = {8'd0, h_q};
			ladrc_pkg::REG_TRACK_SPEED: prdata = {8'd0, r_q};
			ladrc_pkg::REG_CONTROL_BW:  prdata = {8'd0, wc_q};
			ladrc_pkg::REG_OBSERVER_BW: prdata = {8'd0, w0_q};
			ladrc_pkg::REG_PLANT_GAIN:  prdata = {1'b0, b0_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= 24'd16777;
			r_q         <= '0;
			wc_q        <= '0;
			w0_q        <= '0;
			b0_q        <= 31'd65536;
			pc_q        <= '0;
			alu_start_q <= 1'b0;
			div_start_q <= 1'b0;
			for (int i = 0; i < 20; i++) rf_q[i] <= '0;
		end else begin
			alu_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[ladrc_pkg::ADDR_WIDTH-1:2])
					ladrc_pkg::REG_STEP_TIME:   h_q  <= pwdata[23:0];
					ladrc_pkg::REG_TRACK_SPEED: r_q  <= pwdata[23:0];
					ladrc_pkg::REG_CONTROL_BW:  wc_q <= pwdata[23:0];
					ladrc_pkg::REG_OBSERVER_BW: w0_q <= pwdata[23:0];
					ladrc_pkg::REG_PLANT_GAIN:  b0_q <= pwdata[30:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_word.action) begin
							rf_q[R_Z1] <= '0;
							rf_q[R_Z2] <= '0;
							rf_q[R_Z3] <= '0;
						end else begin
							rf_q[R_X]  <= W'(in_word.setpoint);
							rf_q[R_Y]  <= W'(in_word.measurement);
							rf_q[R_R]  <= W'(r_q) << (FRAC_BITS - 8);
							rf_q[R_WC] <= W'(wc_q) << (FRAC_BITS - 8);
							rf_q[R_W0] <= W'(w0_q) << (FRAC_BITS - 8);
							rf_q[R_H]  <= W'(h_q);
							rf_q[R_B0] <= W'((b0_q == '0) ? 31'd1 : b0_q);
							pc_q        <= '0;
							alu_start_q <= 1'b1;
							state_q     <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (alu_done) begin
						rf_q[ins.d] <= alu_y;
						if (pc_q == LAST_PC) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end else begin
							pc_q        <= pc_q + 6'd1;
							alu_start_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						rf_q[R_LD] <= W'(div_q);
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_word.drive   = div_q;
	assign out_word.clamped = div_clip;
endmodule
